// File: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// implication with a fixed delay, given by n, before the consequent
`define ASSERT_LAT(lbl, clk, rst_n, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("latency check failed");

`endif

// File: src/hvn_pkg.sv
// types and constants for the heightmap vertex normal block
// no dependencies; used by the top level, the checker and the bench
package hvn_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_HEIGHT_SCALE = 2'd2
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SIDE_W     = 11;
  localparam int unsigned SCALE_W    = 16;

  localparam logic [SIDE_W-1:0]  WIDTH_RST  = 11'd256;
  localparam logic [SIDE_W-1:0]  HEIGHT_RST = 11'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 16'd410;

  // arithmetic widths
  localparam int unsigned MAG_W  = 26;  // |X|, |Z| magnitude
  localparam int unsigned PROD_W = 28;  // signed X, Z
  localparam int unsigned SQ_W   = 54;  // sum of squares
  localparam int unsigned LEN_W  = 27;  // integer root
  localparam int unsigned QUO_W  = 16;  // quotient bits of each divide
  localparam int unsigned NDEN_W = LEN_W + 1;
  localparam int unsigned NNUM_W = NDEN_W + QUO_W;
  localparam int unsigned TNUM_W = SIDE_W + QUO_W;

  // up term: 4096 * 6 in magnitude, always negative
  localparam logic [MAG_W-1:0] UP_MAG = 26'd24576;
  localparam logic [SQ_W-1:0]  UP_SQ  = 54'd603979776;
  localparam logic [15:0]      Q15_MAX = 16'd32767;

  // pipeline depths
  localparam int unsigned SQ_STAGES  = LEN_W;
  localparam int unsigned DIV_STAGES = QUO_W;
  localparam int unsigned SIDE_D     = SQ_STAGES + DIV_STAGES + 5;
  localparam int unsigned OUT_LAT    = SIDE_D + 1;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] h_centre;
    logic [7:0] h_b_minus;
    logic [7:0] h_a_plus;
    logic [7:0] h_b_plus;
    logic [7:0] h_both_plus;
    logic [7:0] h_a_minus;
    logic [7:0] h_both_minus;
  } vtx_in_t;

  typedef struct packed {
    logic [9:0]         out_col;
    logic [9:0]         out_row;
    logic [23:0]        height_scaled;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic signed [15:0] normal_a;
    logic signed [15:0] normal_up;
    logic signed [15:0] normal_b;
    logic               normal_valid;
  } vtx_out_t;

  // per-word side band carried along the pipeline
  typedef struct packed {
    logic [9:0]       col;
    logic [9:0]       row;
    logic [23:0]      hscaled;
    logic             interior;
    logic             sat_u;
    logic             sat_v;
    logic             neg_x;
    logic             neg_z;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_z;
    logic             len_nz;
  } side_t;

endpackage

// File: src/hvn_isqrt_pipe.sv
// pipelined integer square root, one result bit per stage
// depends on nothing; used by the top level
module hvn_isqrt_pipe #(
  parameter int unsigned R_W = 27
) (
  input  logic             clk_i,
  input  logic [2*R_W-1:0] sq_i,
  output logic [R_W-1:0]   root_o
);

  localparam int unsigned S_W = 2 * R_W;

  logic [S_W-1:0] rem_q  [R_W];
  logic [S_W-1:0] root_q [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int unsigned SH = 2 * (R_W - 1 - k);
    localparam logic [S_W-1:0] POW = {{(S_W-1){1'b0}}, 1'b1} << SH;
    logic [S_W-1:0] rem_in, root_in, trial, rem_d, root_d;

    if (k == 0) begin : g_first
      assign rem_in  = sq_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // trial subtract of root plus the current power of four
    assign trial = root_in + POW;
    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + POW;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
    end
  end

  assign root_o = root_q[R_W-1][R_W-1:0];

endmodule

// File: src/hvn_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
// depends on nothing; numerator must stay below den shifted by Q_W
module hvn_div_pipe #(
  parameter int unsigned D_W = 28,
  parameter int unsigned Q_W = 16
) (
  input  logic               clk_i,
  input  logic [D_W+Q_W-1:0] num_i,
  input  logic [D_W-1:0]     den_i,
  output logic [Q_W-1:0]     quo_o
);

  localparam int unsigned R_W = D_W + Q_W;

  logic [R_W-1:0] rem_q [Q_W];
  logic [D_W-1:0] den_q [Q_W];
  logic [Q_W-1:0] quo_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned SH = Q_W - 1 - k;
    logic [R_W-1:0] rem_in, trial, rem_d;
    logic [D_W-1:0] den_in;
    logic [Q_W-1:0] quo_in, quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // compare against the divisor at this bit weight
    assign trial = R_W'(den_in) << SH;
    always_comb begin
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        quo_d = quo_in | (Q_W'(1) << SH);
      end else begin
        rem_d = rem_in;
        quo_d = quo_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      quo_q[k] <= quo_d;
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

// File: src/heightmap_vertex_normal.sv
// heightmap vertex builder: scaled height, texture coordinates, averaged normal
// depends on hvn_pkg, hvn_isqrt_pipe and hvn_div_pipe
//
//   channel  handshake                  payload
//   input    start_i high, busy_o low   item_i     (hvn_pkg::vtx_in_t)
//   result   done_o strobe, one cycle   result_o   (hvn_pkg::vtx_out_t)
//   config   cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// A word may enter in every cycle; its result strobes on done_o out of the output
// register. The depth is set mainly by the 27-stage square root of the sum of
// squares followed by the 16-stage quotient divide that scales the normal.
// busy_o stays low and the pipeline never stalls, as results cannot be held.
// Reset clears the valid line and sets the configuration registers to their defaults.
module heightmap_vertex_normal #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  hvn_pkg::vtx_in_t                    item_i,
  output logic                                done_o,
  output hvn_pkg::vtx_out_t                   result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hvn_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned SW  = hvn_pkg::SIDE_W;
  localparam int unsigned SD  = hvn_pkg::SIDE_D;
  localparam int unsigned IDX_LEN  = hvn_pkg::SQ_STAGES + 3;
  localparam int unsigned IDX_PREP = hvn_pkg::SQ_STAGES + 4;
  localparam logic [SW-1:0] SIDE_CLAMP =
    (MAX_SIDE > 2047) ? {SW{1'b1}} : SW'(MAX_SIDE);

  // configuration registers
  logic [SW-1:0]                  width_q, width_d;
  logic [SW-1:0]                  height_q, height_d;
  logic [hvn_pkg::SCALE_W-1:0]    scale_q, scale_d;
  logic [SW-1:0]                  side_val;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign side_val    = (cfg_data_i[SW-1:0] > SIDE_CLAMP) ? SIDE_CLAMP : cfg_data_i[SW-1:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    scale_d  = scale_q;
    if (cfg_valid_i) begin
      unique case (hvn_pkg::cfg_reg_e'(cfg_index_i))
        hvn_pkg::CFG_GRID_WIDTH:   width_d  = side_val;
        hvn_pkg::CFG_GRID_HEIGHT:  height_d = side_val;
        hvn_pkg::CFG_HEIGHT_SCALE: scale_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= hvn_pkg::WIDTH_RST;
      height_q <= hvn_pkg::HEIGHT_RST;
      scale_q  <= hvn_pkg::SCALE_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      scale_q  <= scale_d;
    end
  end

  // valid line
  logic [SD-1:0] vld_q, vld_d;
  logic          done_q;

  assign vld_d = {vld_q[SD-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[SD-1];
    end
  end

  // stage 1: height differences folded over the six triangles
  logic signed [10:0] h_c, h_bm, h_ap, h_bp, h_pp, h_am, h_mm;
  logic signed [10:0] s1_xh_d, s1_zh_d, s1_xh_q, s1_zh_q;
  logic [7:0]         s1_hc_q;

  assign h_c  = $signed({3'b000, item_i.h_centre});
  assign h_bm = $signed({3'b000, item_i.h_b_minus});
  assign h_ap = $signed({3'b000, item_i.h_a_plus});
  assign h_bp = $signed({3'b000, item_i.h_b_plus});
  assign h_pp = $signed({3'b000, item_i.h_both_plus});
  assign h_am = $signed({3'b000, item_i.h_a_minus});
  assign h_mm = $signed({3'b000, item_i.h_both_minus});

  assign s1_xh_d = (h_ap <<< 1) + h_pp - h_bp - (h_am <<< 1) + h_bm - h_mm;
  assign s1_zh_d = (h_bp <<< 1) + h_bp - (h_bm <<< 1) + h_am - h_mm - h_c;

  // stage 2, 3 and 4 arithmetic
  logic signed [hvn_pkg::PROD_W-1:0] s2_x_d, s2_z_d, s2_x_q, s2_z_q;
  logic [hvn_pkg::MAG_W-1:0]         mag_x, mag_z;
  logic [2*hvn_pkg::MAG_W-1:0]       s3_x2_d, s3_z2_d, s3_x2_q, s3_z2_q;
  logic [hvn_pkg::SQ_W-1:0]          s4_sum_d, s4_sum_q;

  assign s2_x_d = hvn_pkg::PROD_W'(s1_xh_q) * hvn_pkg::PROD_W'($signed({1'b0, scale_q}));
  assign s2_z_d = hvn_pkg::PROD_W'(s1_zh_q) * hvn_pkg::PROD_W'($signed({1'b0, scale_q}));

  assign mag_x   = s2_x_q[hvn_pkg::PROD_W-1] ? hvn_pkg::MAG_W'(-s2_x_q)
                                              : hvn_pkg::MAG_W'(s2_x_q);
  assign mag_z   = s2_z_q[hvn_pkg::PROD_W-1] ? hvn_pkg::MAG_W'(-s2_z_q)
                                              : hvn_pkg::MAG_W'(s2_z_q);
  assign s3_x2_d = (2*hvn_pkg::MAG_W)'(mag_x) * (2*hvn_pkg::MAG_W)'(mag_x);
  assign s3_z2_d = (2*hvn_pkg::MAG_W)'(mag_z) * (2*hvn_pkg::MAG_W)'(mag_z);
  assign s4_sum_d = hvn_pkg::SQ_W'(s3_x2_q) + hvn_pkg::SQ_W'(s3_z2_q) + hvn_pkg::UP_SQ;

  always_ff @(posedge clk_i) begin
    s1_hc_q  <= item_i.h_centre;
    s1_xh_q  <= s1_xh_d;
    s1_zh_q  <= s1_zh_d;
    s2_x_q   <= s2_x_d;
    s2_z_q   <= s2_z_d;
    s3_x2_q  <= s3_x2_d;
    s3_z2_q  <= s3_z2_d;
    s4_sum_q <= s4_sum_d;
  end

  // root of the sum of squares
  logic [hvn_pkg::LEN_W-1:0] len;

  hvn_isqrt_pipe #(
    .R_W (hvn_pkg::LEN_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .sq_i   (s4_sum_q),
    .root_o (len)
  );

  // side band line, filled in as the word moves on
  hvn_pkg::side_t side_q [SD];
  hvn_pkg::side_t side_d [SD];

  always_comb begin
    for (int k = 1; k < SD; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[0]          = '0;
    side_d[0].col      = item_i.col;
    side_d[0].row      = item_i.row;
    side_d[0].interior = (item_i.col != '0) && (item_i.row != '0) &&
                         ((SW'(item_i.col) + SW'(1)) < width_q) &&
                         ((SW'(item_i.row) + SW'(1)) < height_q);
    side_d[0].sat_u    = (width_q == '0) || (SW'(item_i.col) >= width_q);
    side_d[0].sat_v    = (height_q == '0) || (SW'(item_i.row) >= height_q);
    side_d[1].hscaled  = 24'(s1_hc_q) * 24'(scale_q);
    side_d[2].neg_x    = s2_x_q[hvn_pkg::PROD_W-1];
    side_d[2].neg_z    = s2_z_q[hvn_pkg::PROD_W-1];
    side_d[2].mag_x    = mag_x;
    side_d[2].mag_z    = mag_z;
    side_d[IDX_PREP].len_nz = (len != '0);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SD; k++) begin
      side_q[k] <= side_d[k];
    end
  end

  // numerators and divisor for the normal scaling
  logic [hvn_pkg::NNUM_W-1:0] pr_num_x_q, pr_num_z_q, pr_num_up_q;
  logic [hvn_pkg::NNUM_W-1:0] pr_num_x_d, pr_num_z_d, pr_num_up_d;
  logic [hvn_pkg::NDEN_W-1:0] pr_den_q, pr_den_d;

  assign pr_num_x_d  = (hvn_pkg::NNUM_W'(side_q[IDX_LEN].mag_x) << hvn_pkg::QUO_W) +
                       hvn_pkg::NNUM_W'(len);
  assign pr_num_z_d  = (hvn_pkg::NNUM_W'(side_q[IDX_LEN].mag_z) << hvn_pkg::QUO_W) +
                       hvn_pkg::NNUM_W'(len);
  assign pr_num_up_d = (hvn_pkg::NNUM_W'(hvn_pkg::UP_MAG) << hvn_pkg::QUO_W) +
                       hvn_pkg::NNUM_W'(len);
  assign pr_den_d    = {len, 1'b0};

  always_ff @(posedge clk_i) begin
    pr_num_x_q  <= pr_num_x_d;
    pr_num_z_q  <= pr_num_z_d;
    pr_num_up_q <= pr_num_up_d;
    pr_den_q    <= pr_den_d;
  end

  // dividers: three normal components and two texture coordinates
  logic [hvn_pkg::QUO_W-1:0] quo_x, quo_z, quo_up, quo_u, quo_v;

  hvn_div_pipe #(.D_W(hvn_pkg::NDEN_W), .Q_W(hvn_pkg::QUO_W)) u_div_x (
    .clk_i (clk_i), .num_i (pr_num_x_q), .den_i (pr_den_q), .quo_o (quo_x)
  );
  hvn_div_pipe #(.D_W(hvn_pkg::NDEN_W), .Q_W(hvn_pkg::QUO_W)) u_div_up (
    .clk_i (clk_i), .num_i (pr_num_up_q), .den_i (pr_den_q), .quo_o (quo_up)
  );
  hvn_div_pipe #(.D_W(hvn_pkg::NDEN_W), .Q_W(hvn_pkg::QUO_W)) u_div_z (
    .clk_i (clk_i), .num_i (pr_num_z_q), .den_i (pr_den_q), .quo_o (quo_z)
  );
  hvn_div_pipe #(.D_W(SW), .Q_W(hvn_pkg::QUO_W)) u_div_u (
    .clk_i (clk_i),
    .num_i (hvn_pkg::TNUM_W'({side_q[IDX_PREP].col, 16'h0000})),
    .den_i (width_q),
    .quo_o (quo_u)
  );
  hvn_div_pipe #(.D_W(SW), .Q_W(hvn_pkg::QUO_W)) u_div_v (
    .clk_i (clk_i),
    .num_i (hvn_pkg::TNUM_W'({side_q[IDX_PREP].row, 16'h0000})),
    .den_i (height_q),
    .quo_o (quo_v)
  );

  // clamp to q1.15 and apply sign
  function automatic logic signed [15:0] to_q15(input logic [15:0] q, input logic neg);
    logic [15:0] m;
    m = (q > hvn_pkg::Q15_MAX) ? hvn_pkg::Q15_MAX : q;
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // output register
  hvn_pkg::vtx_out_t res_q, res_d;
  hvn_pkg::side_t    sd;
  logic              nvalid;

  assign sd     = side_q[SD-1];
  assign nvalid = sd.interior & sd.len_nz;

  always_comb begin
    res_d.out_col       = sd.col;
    res_d.out_row       = sd.row;
    res_d.height_scaled = sd.hscaled;
    res_d.tex_u         = sd.sat_u ? 16'hFFFF : quo_u;
    res_d.tex_v         = sd.sat_v ? 16'hFFFF : quo_v;
    res_d.normal_a      = nvalid ? to_q15(quo_x, sd.neg_x) : '0;
    res_d.normal_up     = nvalid ? to_q15(quo_up, 1'b1) : '0;
    res_d.normal_b      = nvalid ? to_q15(quo_z, sd.neg_z) : '0;
    res_d.normal_valid  = nvalid;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: src/hvn_checker.sv
// port-level checks for heightmap_vertex_normal, bound to the top level
// depends on hvn_pkg and assert_macros.svh
`include "assert_macros.svh"

module hvn_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input hvn_pkg::vtx_out_t result_o
);

  // every accepted word strobes out after the fixed latency
  `ASSERT_LAT(a_latency, clk_i, rst_ni, start_i && !busy_o, 49, done_o)

  // no word appears that was not accepted
  `ASSERT_IMP(a_no_extra, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 49))

  // a border word carries a zero normal
  `ASSERT_IMP(a_border_zero, clk_i, rst_ni, done_o && !result_o.normal_valid,
    result_o.normal_a == '0 && result_o.normal_up == '0 && result_o.normal_b == '0)

  // an interior word points down the height axis and lies off the first row and column
  `ASSERT_IMP(a_interior, clk_i, rst_ni, done_o && result_o.normal_valid,
    result_o.normal_up[15] && result_o.out_col != '0 && result_o.out_row != '0)

endmodule

bind heightmap_vertex_normal hvn_checker u_hvn_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

// File: verif/heightmap_vertex_normal_test.sv
// self-checking bench for heightmap_vertex_normal: drives directed and random vertex
// words and register writes, predicts each result in-line and compares whole words
// depends on hvn_pkg and the heightmap_vertex_normal rtl
`timescale 1ns / 100ps

module heightmap_vertex_normal_test;

  localparam int unsigned LAT       = 49;
  localparam int unsigned MAX_SIDE  = 1024;
  localparam int unsigned N_RANDOM  = 1950;
  localparam longint      CYCLE_CAP = 400000;

  typedef struct {
    logic              is_cfg;
    hvn_pkg::cfg_reg_e reg_idx;
    logic [15:0]       reg_data;
    hvn_pkg::vtx_in_t  vtx;
  } job_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  hvn_pkg::vtx_in_t  item_i;
  logic              done_o;
  hvn_pkg::vtx_out_t result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [15:0]       cfg_data_i;

  heightmap_vertex_normal uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor copy of the registers
  longint unsigned width_q, height_q, scale_q;

  job_t              pending_jobs[$];
  hvn_pkg::vtx_out_t expected_vertices[$];
  int       mismatches;
  int       gap_left;
  bit       quiet_phase;
  bit       drain_done;
  longint   cycle_count;

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_q15(longint c, longint unsigned len);
    longint unsigned mag, q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = (mag * 65536 + len) / (2 * len);
    if (q > 32767) q = 32767;
    return (c < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic logic [15:0] tex_q16(longint unsigned pos, longint unsigned size);
    longint unsigned t;
    if (size == 0) return 16'hFFFF;
    t = (pos << 16) / size;
    return (t > 65535) ? 16'hFFFF : 16'(t);
  endfunction

  // vertex position tables: a, b offsets of the seven window points
  // order: centre, b-1, a+1, b+1, both+1, a-1, both-1
  function automatic hvn_pkg::vtx_out_t predict_vertex(hvn_pkg::vtx_in_t w);
    hvn_pkg::vtx_out_t o;
    longint  pa[7], ph[7], pb[7];
    int      tri_idx[6][3];
    longint  nx, nu, nz, p1, q1, r1, p2, q2, r2;
    longint unsigned s, len;
    bit      interior;
    pa = '{0, 0, 1, 0, 1, -1, -1};
    pb = '{0, -1, 0, 1, 1, 0, -1};
    ph[0] = w.h_centre * scale_q;
    ph[1] = w.h_b_minus * scale_q;
    ph[2] = w.h_a_plus * scale_q;
    ph[3] = w.h_b_plus * scale_q;
    ph[4] = w.h_both_plus * scale_q;
    ph[5] = w.h_a_minus * scale_q;
    ph[6] = w.h_both_minus * scale_q;
    tri_idx = '{'{0, 1, 2}, '{0, 2, 3}, '{0, 4, 3}, '{0, 3, 5}, '{0, 5, 6}, '{0, 6, 1}};
    o = '0;
    o.out_col = w.col;
    o.out_row = w.row;
    o.height_scaled = 24'(ph[0]);
    o.tex_u = tex_q16(w.col, width_q);
    o.tex_v = tex_q16(w.row, height_q);
    interior = w.col != 0 && w.row != 0 && (w.col + 1) < width_q && (w.row + 1) < height_q;
    if (interior) begin
      nx = 0; nu = 0; nz = 0;
      for (int t = 0; t < 6; t++) begin
        p1 = pa[tri_idx[t][1]] - pa[tri_idx[t][0]];
        q1 = ph[tri_idx[t][1]] - ph[tri_idx[t][0]];
        r1 = pb[tri_idx[t][1]] - pb[tri_idx[t][0]];
        p2 = pa[tri_idx[t][2]] - pa[tri_idx[t][1]];
        q2 = ph[tri_idx[t][2]] - ph[tri_idx[t][1]];
        r2 = pb[tri_idx[t][2]] - pb[tri_idx[t][1]];
        nx += q1 * r2 - r1 * q2;
        nu += r1 * p2 - p1 * r2;
        nz += p1 * q2 - q1 * p2;
      end
      nu *= 4096;
      s = nx * nx + nu * nu + nz * nz;
      len = root_floor(s);
      if (len != 0) begin
        o.normal_a = unit_q15(nx, len);
        o.normal_up = unit_q15(nu, len);
        o.normal_b = unit_q15(nz, len);
        o.normal_valid = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic job_t vertex_job(hvn_pkg::vtx_in_t w);
    job_t j;
    j.is_cfg = 1'b0;
    j.reg_idx = hvn_pkg::CFG_GRID_WIDTH;
    j.reg_data = '0;
    j.vtx = w;
    return j;
  endfunction

  function automatic job_t reg_job(hvn_pkg::cfg_reg_e idx, logic [15:0] data);
    job_t j;
    j.is_cfg = 1'b1;
    j.reg_idx = idx;
    j.reg_data = data;
    j.vtx = '0;
    return j;
  endfunction

  // random word: mostly interior coordinates, sometimes border or beyond size
  function automatic hvn_pkg::vtx_in_t random_vertex();
    hvn_pkg::vtx_in_t w;
    w = hvn_pkg::vtx_in_t'(76'({$urandom, $urandom, $urandom}));
    case ($urandom_range(0, 9))
      0: w.col = 10'($urandom_range(0, 2));
      1: w.row = 10'($urandom_range(0, 2));
      2, 3: ;
      default: begin
        w.col = 10'($urandom_range(1, 1023) % ((width_q > 2) ? width_q - 1 : 1));
        w.row = 10'($urandom_range(1, 1023) % ((height_q > 2) ? height_q - 1 : 1));
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      // flat terrain
      w.h_b_minus = w.h_centre; w.h_a_plus = w.h_centre; w.h_b_plus = w.h_centre;
      w.h_both_plus = w.h_centre; w.h_a_minus = w.h_centre; w.h_both_minus = w.h_centre;
    end
    return w;
  endfunction

  // driver: one nonblocking write per signal per edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i     <= 1'b0;
      item_i      <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i  <= '0;
      gap_left    <= 0;
    end else begin
      automatic bit start_taken = start_i && !busy_o;
      automatic bit cfg_taken = cfg_valid_i && cfg_ready_o;
      automatic bit slot_free = (!start_i || start_taken) && (!cfg_valid_i || cfg_taken);
      if (start_taken) expected_vertices = {expected_vertices, predict_vertex(item_i)};
      if (cfg_taken) begin
        case (hvn_pkg::cfg_reg_e'(cfg_index_i))
          hvn_pkg::CFG_GRID_WIDTH:
            width_q = (cfg_data_i[10:0] > MAX_SIDE) ? MAX_SIDE : cfg_data_i[10:0];
          hvn_pkg::CFG_GRID_HEIGHT:
            height_q = (cfg_data_i[10:0] > MAX_SIDE) ? MAX_SIDE : cfg_data_i[10:0];
          hvn_pkg::CFG_HEIGHT_SCALE: scale_q = cfg_data_i;
          default: ;
        endcase
      end
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (pending_jobs.size() != 0 && pending_jobs[0].is_cfg) begin
          start_i <= 1'b0;
          cfg_valid_i <= 1'b1;
          cfg_index_i <= pending_jobs[0].reg_idx;
          cfg_data_i <= pending_jobs[0].reg_data;
          void'(pending_jobs.pop_front());
        end else if (pending_jobs.size() != 0) begin
          cfg_valid_i <= 1'b0;
          if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            start_i <= 1'b0;
            gap_left <= $urandom_range(0, 3);
          end else begin
            start_i <= 1'b1;
            item_i <= pending_jobs[0].vtx;
            void'(pending_jobs.pop_front());
          end
        end else begin
          start_i <= 1'b0;
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: each strobed word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", result_o);
      end else begin
        automatic hvn_pkg::vtx_out_t want = expected_vertices.pop_front();
        if (want !== result_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, result_o);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // append one job to the pending list
  task automatic add_job(job_t j);
    pending_jobs = {pending_jobs, j};
  endtask

  // run one phase and wait until the pipeline has emptied
  task automatic run_phase();
    while (pending_jobs.size() != 0 || start_i || cfg_valid_i) @(posedge clk_i);
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic queue_config(logic [15:0] w, logic [15:0] h, logic [15:0] sc);
    add_job(reg_job(hvn_pkg::CFG_GRID_WIDTH, w));
    add_job(reg_job(hvn_pkg::CFG_GRID_HEIGHT, h));
    add_job(reg_job(hvn_pkg::CFG_HEIGHT_SCALE, sc));
  endtask

  initial begin
    hvn_pkg::vtx_in_t w;
    logic [15:0] settings[6][3];
    mismatches = 0;
    cycle_count = 0;
    quiet_phase = 1'b0;
    width_q = hvn_pkg::WIDTH_RST;
    height_q = hvn_pkg::HEIGHT_RST;
    scale_q = hvn_pkg::SCALE_RST;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words under reset settings
    w = '0;
    add_job(vertex_job(w));
    w = '1;
    add_job(vertex_job(w));
    w.col = 10'd1; w.row = 10'd1;
    add_job(vertex_job(w));
    w.col = 10'd254; w.row = 10'd254;
    add_job(vertex_job(w));
    w.col = 10'd255; w.row = 10'd100;
    add_job(vertex_job(w));
    w = '0; w.col = 10'd100; w.row = 10'd255;
    add_job(vertex_job(w));
    w = hvn_pkg::vtx_in_t'({10'd5, 10'd5, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
    add_job(vertex_job(w));
    w = hvn_pkg::vtx_in_t'({10'd5, 10'd6, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
    add_job(vertex_job(w));
    w = hvn_pkg::vtx_in_t'({10'd7, 10'd7, 8'd128, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255});
    add_job(vertex_job(w));
    w = hvn_pkg::vtx_in_t'({10'd9, 10'd3, 8'd1, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0});
    add_job(vertex_job(w));
    run_phase();

    // settings: extremes, zero sizes, clamped sizes, a mid-range set
    settings = '{'{16'd2, 16'd2, 16'd0},
                 '{16'd1024, 16'd1024, 16'hFFFF},
                 '{16'd0, 16'd3, 16'd4096},
                 '{16'hFFFF, 16'd2047, 16'd1},
                 '{16'd3, 16'd0, 16'h8000},
                 '{16'd17, 16'd600, 16'd410}};
    for (int p = 0; p < 6; p++) begin
      queue_config(settings[p][0], settings[p][1], settings[p][2]);
      run_phase();
      for (int i = 0; i < 60; i++) add_job(vertex_job(random_vertex()));
      run_phase();
    end

    // random settings with long random stretches
    for (int p = 0; p < 4; p++) begin
      queue_config(16'($urandom_range(2, 1024)), 16'($urandom_range(2, 1024)),
                   16'($urandom));
      run_phase();
      quiet_phase = (p == 3);
      for (int i = 0; i < 400; i++) add_job(vertex_job(random_vertex()));
      run_phase();
    end

    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/hvn_pkg.sv
src/hvn_isqrt_pipe.sv
src/hvn_div_pipe.sv
src/heightmap_vertex_normal.sv
src/hvn_checker.sv
verif/heightmap_vertex_normal_test.sv
